@@ rtl/core/mbe_pkg.sv @@
package mbe_pkg;

  // behaviour constants
  localparam int unsigned MAX_ITERATIONS = 256;
  localparam int unsigned MAX_DIM        = 4096;
  localparam int unsigned FIFO_DEPTH     = 2;
  localparam int unsigned FRAC_BITS      = 28;

  // iteration counter must hold MAX_ITERATIONS itself
  localparam int unsigned CNT_W = $clog2(MAX_ITERATIONS + 1);

  localparam logic [63:0] BAILOUT_Q56 = 64'd4 << (2 * FRAC_BITS);

  typedef enum logic [1:0] {
    REG_ORIGIN_RE = 2'd0,
    REG_ORIGIN_IM = 2'd1,
    REG_STEP_RE   = 2'd2,
    REG_STEP_IM   = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD
  } back_state_e;

  typedef struct packed {
    logic signed [31:0] origin_re;
    logic signed [31:0] origin_im;
    logic [30:0]        step_re;
    logic [30:0]        step_im;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] c_re;
    logic signed [31:0] c_im;
  } cpoint_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // saturate a wide signed value to the signed q4.28 range
  function automatic logic signed [31:0] sat_q(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [11:0] clamp_index(input logic [11:0] v);
    logic [11:0] r;
    if (17'(v) >= 17'(MAX_DIM)) begin
      r = 12'(MAX_DIM - 1);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/mbe_front.sv @@
module mbe_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mbe_pkg::cfg_t            cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [11:0]              pixel_x_i,
  input  logic [11:0]              pixel_y_i,
  output logic                     push_o,
  output mbe_pkg::cpoint_t         point_o,
  input  logic                     q_full_i
);

  logic        valid_q, valid_d;
  logic [42:0] prod_re_q, prod_re_d;
  logic [42:0] prod_im_q, prod_im_d;
  logic signed [47:0] sum_re, sum_im;
  logic        take;

  assign push_o     = valid_q && !q_full_i;
  assign in_ready_o = !valid_q || !q_full_i;
  assign take       = in_valid_i && in_ready_o;

  assign prod_re_d = mbe_pkg::clamp_index(pixel_x_i) * cfg_i.step_re;
  assign prod_im_d = mbe_pkg::clamp_index(pixel_y_i) * cfg_i.step_im;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      prod_re_q <= prod_re_d;
      prod_im_q <= prod_im_d;
    end
  end

  // origin plus offset, both widened to 48 bits before saturation
  assign sum_re = {{16{cfg_i.origin_re[31]}}, cfg_i.origin_re} + {5'b0, prod_re_q};
  assign sum_im = {{16{cfg_i.origin_im[31]}}, cfg_i.origin_im} + {5'b0, prod_im_q};

  assign point_o.c_re = mbe_pkg::sat_q(sum_re);
  assign point_o.c_im = mbe_pkg::sat_q(sum_im);

endmodule

@@ rtl/core/mbe_fifo.sv @@
module mbe_fifo #(
  parameter int unsigned Depth = mbe_pkg::FIFO_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  mbe_pkg::cpoint_t      wdata_i,
  input  logic                  pop_i,
  output mbe_pkg::cpoint_t      rdata_o,
  output mbe_pkg::fifo_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mbe_pkg::cpoint_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign status_o.empty = (cnt_q == '0);
  assign rdata_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ rtl/core/mbe_back.sv @@
module mbe_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  mbe_pkg::cpoint_t point_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       escape_value_o
);

  localparam int unsigned CntW = mbe_pkg::CNT_W;

  mbe_pkg::back_state_e state_q, state_d;

  logic signed [31:0] c_re_q, c_im_q;
  logic signed [31:0] x_q, y_q;
  logic [CntW-1:0]    cnt_q;
  logic signed [63:0] xx_q, yy_q, xy_q;
  logic signed [63:0] xx_d, yy_d, xy_d;

  logic signed [63:0] diff;
  logic [63:0]        mag;
  logic signed [47:0] nx_sum, ny_sum;
  logic               done;
  logic               out_free;
  logic               load, mul_en, step_en, emit;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_data_q;

  assign xx_d = x_q * x_q;
  assign yy_d = y_q * y_q;
  assign xy_d = x_q * y_q;

  // squares are never negative, so the sum fits unsigned in 64 bits
  assign mag    = {1'b0, xx_q[62:0]} + {1'b0, yy_q[62:0]};
  assign diff   = xx_q - yy_q;
  assign nx_sum = {{12{diff[63]}}, diff[63:28]} + {{16{c_re_q[31]}}, c_re_q};
  assign ny_sum = {{11{xy_q[63]}}, xy_q[63:27]} + {{16{c_im_q[31]}}, c_im_q};

  assign done     = (mag >= mbe_pkg::BAILOUT_Q56) ||
                    (cnt_q >= CntW'(mbe_pkg::MAX_ITERATIONS));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mbe_pkg::ST_IDLE: begin
        if (q_valid_i) state_d = mbe_pkg::ST_MUL;
      end
      mbe_pkg::ST_MUL: begin
        state_d = mbe_pkg::ST_UPD;
      end
      mbe_pkg::ST_UPD: begin
        if (!done) begin
          state_d = mbe_pkg::ST_MUL;
        end else if (out_free) begin
          state_d = mbe_pkg::ST_IDLE;
        end
      end
      default: state_d = mbe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    load    = 1'b0;
    mul_en  = 1'b0;
    step_en = 1'b0;
    emit    = 1'b0;
    unique case (state_q)
      mbe_pkg::ST_IDLE: load    = q_valid_i;
      mbe_pkg::ST_MUL:  mul_en  = 1'b1;
      mbe_pkg::ST_UPD: begin
        step_en = !done;
        emit    = done && out_free;
      end
      default: ;
    endcase
  end

  assign pop_o = load;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbe_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      c_re_q <= point_i.c_re;
      c_im_q <= point_i.c_im;
      x_q    <= '0;
      y_q    <= '0;
      cnt_q  <= '0;
    end else if (step_en) begin
      x_q   <= mbe_pkg::sat_q(nx_sum);
      y_q   <= mbe_pkg::sat_q(ny_sum);
      cnt_q <= cnt_q + 1'b1;
    end
    if (mul_en) begin
      xx_q <= xx_d;
      yy_q <= yy_d;
      xy_q <= xy_d;
    end
    if (emit) begin
      out_data_q <= 8'(cnt_q - 1'b1);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign escape_value_o = out_data_q;

endmodule

@@ rtl/core/mandelbrot_escape_time.sv @@
// mandelbrot escape-time pixel engine
// write origin_re, origin_im, step_re and step_im through the cfg port
// (index 0 to 3) while the engine is idle; the step registers use the low
// 31 bits of cfg_wdata_i. each beat on the slave stream carries one pixel
// position, and one beat with its escape value leaves on the master stream,
// in the same order.
// the front takes a pixel, registers index * step, forms c = origin +
// index * step and puts it into a two-entry queue, so it keeps taking pixels
// while the back is busy. the back runs the z = z*z + c loop on three 32x32
// multipliers: each iteration forms the products, then does the bailout test
// and update; before the first one the back loads a pixel from the queue.
// a finished result sits in the output register; while the receiver stalls
// the back holds the next finished pixel, the queue fills and then the
// slave tready drops. reset empties the queue, returns the engine to idle
// and clears all configuration registers to zero.
module mandelbrot_escape_time #(
  parameter int unsigned FifoDepth = mbe_pkg::FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // pixel_x [11:0], pixel_y [23:12]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // escape_value [7:0]
);

  mbe_pkg::cfg_t         cfg_q;
  mbe_pkg::cpoint_t      push_point, pop_point;
  mbe_pkg::fifo_status_t q_status;
  logic                  push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (mbe_pkg::cfg_reg_e'(cfg_index_i))
        mbe_pkg::REG_ORIGIN_RE: cfg_q.origin_re <= cfg_wdata_i;
        mbe_pkg::REG_ORIGIN_IM: cfg_q.origin_im <= cfg_wdata_i;
        mbe_pkg::REG_STEP_RE:   cfg_q.step_re   <= cfg_wdata_i[30:0];
        mbe_pkg::REG_STEP_IM:   cfg_q.step_im   <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  mbe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .pixel_x_i  (s_axis_tdata[11:0]),
    .pixel_y_i  (s_axis_tdata[23:12]),
    .push_o     (push),
    .point_o    (push_point),
    .q_full_i   (q_status.full)
  );

  mbe_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (push_point),
    .pop_i    (pop),
    .rdata_o  (pop_point),
    .status_o (q_status)
  );

  mbe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (!q_status.empty),
    .point_i        (pop_point),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .escape_value_o (m_axis_tdata)
  );

  // queue never overruns or underruns
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_status.full))
    else $error("push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && q_status.empty))
    else $error("pop from empty queue");

  // with the slave side stalled on a full queue, the front must not push while it stays full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_status.full && !pop && !push && !s_axis_tready) |=> !push || !q_status.full)
    else $error("front pushed while queue stayed full");

endmodule

@@ bench/tb_mandelbrot_escape_time.sv @@
`timescale 1ns / 100ps

module tb_mandelbrot_escape_time;

  localparam int RandPhases = 10;
  localparam int PhaseItems = 95;
  localparam int Rows       = 20;
  localparam int LongHold   = 3000;
  localparam int TailCycles = 600;

  typedef struct packed {
    logic [31:0] o_re;
    logic [31:0] o_im;
    logic [31:0] s_re;
    logic [31:0] s_im;
    logic [11:0] px;
    logic [11:0] py;
    logic        known;
    logic [7:0]  value;
  } pixel_row_t;

  typedef struct packed {
    logic [11:0] px;
    logic [11:0] py;
    logic [7:0]  value;
  } escape_due_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // pixel_x [11:0], pixel_y [23:12]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // escape_value [7:0]

  // shadow of the view registers as the block holds them
  logic signed [31:0] view_re, view_im;
  logic [30:0]        pitch_re, pitch_im;
  logic [31:0]        loaded [4];

  escape_due_t escapes_due [$];
  pixel_row_t  rows [Rows];
  int          mismatches = 0;
  int          sent = 0;
  int          got = 0;
  int          settings = 0;
  int          at_limit = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  mandelbrot_escape_time DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic signed [31:0] clip_q(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [7:0] escape_count(input logic [11:0] px, input logic [11:0] py);
    longint          c_re, c_im, zr, zi, zr2, zi2, zrzi;
    longint unsigned mag;
    int unsigned     n;
    c_re = clip_q(longint'(view_re) + longint'(px) * longint'(pitch_re));
    c_im = clip_q(longint'(view_im) + longint'(py) * longint'(pitch_im));
    zr = 0;
    zi = 0;
    n = 0;
    forever begin
      zr2 = zr * zr;
      zi2 = zi * zi;
      mag = $unsigned(zr2) + $unsigned(zi2);
      if (mag >= mbe_pkg::BAILOUT_Q56 || n >= mbe_pkg::MAX_ITERATIONS) break;
      zrzi = zr * zi;
      // arithmetic shift of a signed value rounds towards minus infinity
      zr = clip_q(((zr2 - zi2) >>> mbe_pkg::FRAC_BITS) + c_re);
      zi = clip_q((zrzi >>> (mbe_pkg::FRAC_BITS - 1)) + c_im);
      n++;
    end
    return 8'(n - 1);
  endfunction

  task automatic put_word(input mbe_pkg::cfg_reg_e idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [31:0] w_ore, input logic [31:0] w_oim,
                              input logic [31:0] w_sre, input logic [31:0] w_sim);
    put_word(mbe_pkg::REG_ORIGIN_RE, w_ore);
    put_word(mbe_pkg::REG_ORIGIN_IM, w_oim);
    put_word(mbe_pkg::REG_STEP_RE, w_sre);
    put_word(mbe_pkg::REG_STEP_IM, w_sim);
    cfg_we_i <= 1'b0;
    view_re  = w_ore;
    view_im  = w_oim;
    pitch_re = w_sre[30:0];
    pitch_im = w_sim[30:0];
    loaded[mbe_pkg::REG_ORIGIN_RE] = w_ore;
    loaded[mbe_pkg::REG_ORIGIN_IM] = w_oim;
    loaded[mbe_pkg::REG_STEP_RE]   = w_sre;
    loaded[mbe_pkg::REG_STEP_IM]   = w_sim;
    settings++;
  endtask

  // park the sender and let every pending escape value come out
  task automatic wait_all_out();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (escapes_due.size() != 0);
  endtask

  task automatic send_pixel(input logic [11:0] px, input logic [11:0] py,
                            input logic known, input logic [7:0] typed);
    int unsigned gap;
    escape_due_t due;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    due.px = px;
    due.py = py;
    due.value = known ? typed : escape_count(px, py);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {py, px};
    do @(posedge clk_i); while (!s_axis_tready);
    escapes_due.push_back(due);
    sent++;
  endtask

  initial begin : drain_results
    int unsigned gap;
    escape_due_t due;
    wait (rst_ni);
    forever begin
      if (got == 40 || got == 600) begin
        // long stall so the queue fills and the input backs up
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        gap = rx_calm ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
      end
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (escapes_due.size() == 0) begin
        mismatches++;
        $display("%0t: escape value %0d with none expected", $time, m_axis_tdata);
      end else begin
        due = escapes_due.pop_front();
        if (m_axis_tdata !== due.value) begin
          mismatches++;
          $display("%0t: pixel (%0d,%0d) escape expected %0d, got %0d",
                   $time, due.px, due.py, due.value, m_axis_tdata);
        end
      end
      if (m_axis_tdata == 8'hff) at_limit++;
      got++;
      if (got % 40 == 0) rx_calm = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin : run_stimulus
    logic [31:0] w_ore, w_oim, w_sre, w_sim;
    rows = '{
      // reset view: every point is the origin
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        12'h000, 12'h000, 1'b1, 8'd255},
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        12'hfff, 12'hfff, 1'b1, 8'd255},
      // far outside: escapes on the first test after one step
      '{32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        12'h000, 12'h000, 1'b1, 8'd0},
      '{32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        12'hfff, 12'hfff, 1'b1, 8'd0},
      // coordinate saturation, step words with the unused top bit set
      '{32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff,
        12'hfff, 12'hfff, 1'b1, 8'd0},
      '{32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff,
        12'h000, 12'h000, 1'b1, 8'd0},
      '{32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff,
        12'h001, 12'h001, 1'b0, 8'd0},
      '{32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff,
        12'h002, 12'h000, 1'b0, 8'd0},
      // single points on the real and imaginary axes
      '{32'he000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        12'h000, 12'h000, 1'b0, 8'd0},
      '{32'h0400_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        12'h000, 12'h000, 1'b0, 8'd0},
      '{32'hf000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        12'h000, 12'h000, 1'b0, 8'd0},
      '{32'h0000_0000, 32'h1000_0000, 32'h0000_0000, 32'h0000_0000,
        12'h000, 12'h000, 1'b0, 8'd0},
      // whole-set view
      '{32'he000_0000, 32'hee00_0000, 32'h0003_0000, 32'h0002_4000,
        12'haaa, 12'h555, 1'b0, 8'd0},
      '{32'he000_0000, 32'hee00_0000, 32'h0003_0000, 32'h0002_4000,
        12'h555, 12'haaa, 1'b0, 8'd0},
      '{32'he000_0000, 32'hee00_0000, 32'h0003_0000, 32'h0002_4000,
        12'h800, 12'h800, 1'b0, 8'd0},
      '{32'he000_0000, 32'hee00_0000, 32'h0003_0000, 32'h0002_4000,
        12'h7ff, 12'h7ff, 1'b0, 8'd0},
      '{32'he000_0000, 32'hee00_0000, 32'h0003_0000, 32'h0002_4000,
        12'hfff, 12'h000, 1'b0, 8'd0},
      // close to the boundary, slow escapes
      '{32'hf400_0000, 32'h0199_999a, 32'h0000_0100, 32'h0000_0100,
        12'h000, 12'h000, 1'b0, 8'd0},
      '{32'hf400_0000, 32'h0199_999a, 32'h0000_0100, 32'h0000_0100,
        12'h123, 12'h456, 1'b0, 8'd0},
      '{32'h0428_f5c3, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        12'h000, 12'h000, 1'b0, 8'd0}
    };
    view_re  = '0;
    view_im  = '0;
    pitch_re = '0;
    pitch_im = '0;
    foreach (loaded[i]) loaded[i] = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < Rows; r++) begin
      if ({rows[r].o_re, rows[r].o_im, rows[r].s_re, rows[r].s_im} !=
          {loaded[mbe_pkg::REG_ORIGIN_RE], loaded[mbe_pkg::REG_ORIGIN_IM],
           loaded[mbe_pkg::REG_STEP_RE], loaded[mbe_pkg::REG_STEP_IM]}) begin
        wait_all_out();
        apply_config(rows[r].o_re, rows[r].o_im, rows[r].s_re, rows[r].s_im);
      end
      send_pixel(rows[r].px, rows[r].py, rows[r].known, rows[r].value);
    end

    for (int ph = 0; ph < RandPhases; ph++) begin
      wait_all_out();
      case (ph)
        0: begin
          w_ore = $urandom();
          w_oim = $urandom();
          w_sre = $urandom();
          w_sim = $urandom();
        end
        RandPhases - 2: begin
          w_ore = 32'h8000_0000;
          w_oim = 32'h8000_0000;
          w_sre = 32'h7fff_ffff;
          w_sim = 32'h7fff_ffff;
        end
        RandPhases - 1: begin
          w_ore = 32'h7fff_ffff;
          w_oim = 32'h8000_0000;
          w_sre = 32'h0000_0001;
          w_sim = 32'h8000_0001;
        end
        default: begin
          // windows over the set, around -2.5..0.5 and -1.125..1.125
          w_ore = 32'($urandom_range(0, 32'h3000_0000)) - 32'h2800_0000;
          w_oim = 32'($urandom_range(0, 32'h2400_0000)) - 32'h1200_0000;
          w_sre = {1'($urandom_range(0, 1)), 31'($urandom_range(0, 32'h0004_0000))};
          w_sim = {1'($urandom_range(0, 1)), 31'($urandom_range(0, 32'h0004_0000))};
        end
      endcase
      apply_config(w_ore, w_oim, w_sre, w_sim);
      tx_calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PhaseItems; k++) begin
        if (ph == 4 && k == PhaseItems / 2) wait_all_out();
        send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), 1'b0, 8'd0);
      end
    end

    wait_all_out();
    repeat (TailCycles) @(posedge clk_i);
    $display("%0d pixels sent, %0d escape values checked over %0d register settings",
             sent, got, settings);
    $display("%0d of the escape values hit the iteration limit", at_limit);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("timeout with %0d escape values outstanding", escapes_due.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/mbe_pkg.sv
rtl/core/mbe_front.sv
rtl/core/mbe_fifo.sv
rtl/core/mbe_back.sv
rtl/core/mandelbrot_escape_time.sv
bench/tb_mandelbrot_escape_time.sv
